// File: rtl/visibility_transceiver_tracker_macros.svh
// Assertion macros used by the tracker back end (vtt_back).
// Each macro expects clk and rst in scope.
`ifndef VISIBILITY_TRANSCEIVER_TRACKER_MACROS_SVH
`define VISIBILITY_TRANSCEIVER_TRACKER_MACROS_SVH

// Same-cycle implication
`define VTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define VTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtt_pkg;

  // Transceiver action codes
  typedef enum logic [3:0] {
    ACT_UNKNOWN  = 4'd0,
    ACT_KEEP     = 4'd1,
    ACT_DISABLE  = 4'd2,
    ACT_TX_ONLY  = 4'd3,
    ACT_RX_ONLY  = 4'd4,
    ACT_TX_RX    = 4'd5,
    ACT_TX_MOD   = 4'd6,
    ACT_RX_MOD   = 4'd7,
    ACT_BOTH_MOD = 4'd8
  } action_t;

  localparam int UP_W   = 8;
  localparam int TIME_W = 32;
  localparam int LEN_W  = 16;

  // Classified pass word handed from front to back
  typedef struct packed {
    logic            empty;
    logic            last;
    logic            in_sight;
    logic [UP_W-1:0] up;
    logic            dn_any;
  } vtt_word_t;

  // Action from prior and new link state
  function automatic action_t decide_action(input logic [UP_W-1:0] old_up,
                                            input logic            old_dn,
                                            input logic [UP_W-1:0] new_up,
                                            input logic            new_dn);
    logic    had_tx;
    logic    has_tx;
    action_t act;
    had_tx = (old_up != '0);
    has_tx = (new_up != '0);
    if (!has_tx && !new_dn) begin
      act = (had_tx || old_dn) ? ACT_DISABLE : ACT_KEEP;
    end else if ((has_tx && !had_tx) || (new_dn && !old_dn)) begin
      if (has_tx && new_dn) act = ACT_TX_RX;
      else if (has_tx)      act = ACT_TX_ONLY;
      else                  act = ACT_RX_ONLY;
    end else if (had_tx && !has_tx) begin
      act = ACT_RX_ONLY;
    end else if (old_dn && !new_dn) begin
      act = ACT_TX_ONLY;
    end else if ((new_up != old_up) && (new_dn != old_dn)) begin
      act = ACT_BOTH_MOD;
    end else if (new_up != old_up) begin
      act = ACT_TX_MOD;
    end else if (new_dn != old_dn) begin
      act = ACT_RX_MOD;
    end else begin
      act = ACT_KEEP;
    end
    return act;
  endfunction

endpackage

`default_nettype wire

// File: rtl/vtt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vtt_front
  import vtt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [TIME_W-1:0] current_time,
  input  wire logic [TIME_W-1:0] pass_start,
  input  wire logic [LEN_W-1:0]  pass_length,
  input  wire logic [UP_W-1:0]   uplink_generation,
  input  wire logic [7:0]        downlink_generation,
  input  wire logic              last_pass,
  input  wire logic              empty_list,
  output logic                   word_valid,
  input  wire logic              word_ready,
  output vtt_word_t              word
);

  logic [TIME_W-1:0] pass_end;
  logic              in_sight;
  logic              take;

  // Visibility window, end taken modulo 2^32
  assign pass_end = pass_start + {{(TIME_W-LEN_W){1'b0}}, pass_length};
  assign in_sight = (current_time >= pass_start) && (current_time < pass_end);

  assign in_ready = !word_valid || word_ready;
  assign take     = in_valid && in_ready;

  // Stage register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  // Classified word
  always_ff @(posedge clk) begin
    if (take) begin
      word.empty    <= empty_list;
      word.last     <= last_pass;
      word.in_sight <= in_sight;
      word.up       <= uplink_generation;
      word.dn_any   <= (downlink_generation != 8'd0);
    end
  end

endmodule

`default_nettype wire

// File: rtl/vtt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vtt_queue
  import vtt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire vtt_word_t push_word,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output vtt_word_t      pop_word
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vtt_word_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/vtt_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "visibility_transceiver_tracker_macros.svh"

module vtt_back
  import vtt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            word_valid,
  output logic                 word_ready,
  input  wire vtt_word_t       word,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           action,
  output logic [UP_W-1:0]      min_uplink,
  output logic                 downlink_available
);

  logic [UP_W-1:0] run_min_uplink;
  logic            run_downlink;
  logic [UP_W-1:0] prior_uplink;
  logic            prior_downlink;
  logic [UP_W-1:0] min_next;
  logic            dn_next;
  logic            pop;
  logic            emit;

  assign word_ready = !out_valid || out_ready;
  assign pop        = word_valid && word_ready;
  assign emit       = pop && (word.empty || word.last);

  // Running minimum and downlink flag including this pass
  always_comb begin
    min_next = run_min_uplink;
    dn_next  = run_downlink;
    if (word.in_sight) begin
      if ((run_min_uplink == '0) || (word.up < run_min_uplink)) min_next = word.up;
      if (word.dn_any) dn_next = 1'b1;
    end
  end

  // List state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_uplink <= '0;
      run_downlink   <= 1'b0;
      prior_uplink   <= '0;
      prior_downlink <= 1'b0;
    end else if (pop && !word.empty) begin
      if (word.last) begin
        prior_uplink   <= min_next;
        prior_downlink <= dn_next;
        run_min_uplink <= '0;
        run_downlink   <= 1'b0;
      end else begin
        run_min_uplink <= min_next;
        run_downlink   <= dn_next;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_ready) begin
      out_valid <= emit;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (emit) begin
      if (word.empty) begin
        action             <= ACT_UNKNOWN;
        min_uplink         <= '0;
        downlink_available <= 1'b0;
      end else begin
        action             <= decide_action(prior_uplink, prior_downlink,
                                            min_next, dn_next);
        min_uplink         <= min_next;
        downlink_available <= dn_next;
      end
    end
  end

  `VTT_ASSERT_NOW(a_unknown_is_blank, out_valid && (action == ACT_UNKNOWN), (min_uplink == '0) && !downlink_available, "unknown action with nonzero link fields")
  `VTT_ASSERT_NOW(a_idle_links_action, out_valid && (min_uplink == '0) && !downlink_available, (action == ACT_UNKNOWN) || (action == ACT_KEEP) || (action == ACT_DISABLE), "bad action with no links in sight")
  `VTT_ASSERT_NEXT(a_list_end_clears, pop && word.last && !word.empty, (run_min_uplink == '0) && !run_downlink && (prior_uplink == min_uplink), "running state not rolled over at list end")

endmodule

`default_nettype wire

// File: rtl/visibility_transceiver_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Visibility transceiver tracker: takes one pass word per cycle while in_ready is
// high, tests it against the current time, folds in-sight passes into a running
// lowest uplink generation and a downlink flag, and on the last pass of a list
// (or on an empty-list word) delivers one result with the transceiver action
// against the previous list. Throughput is one word per clock unless stalled.
// A word is captured by the front classify register when accepted, moves into
// the pass queue (QUEUE_DEPTH words) and then into the back output register.
// The queue lets the input side keep accepting while a result waits to be taken.
module visibility_transceiver_tracker
  import vtt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [TIME_W-1:0] current_time,
  input  wire logic [TIME_W-1:0] pass_start,
  input  wire logic [LEN_W-1:0]  pass_length,
  input  wire logic [UP_W-1:0]   uplink_generation,
  input  wire logic [7:0]        downlink_generation,
  input  wire logic              last_pass,
  input  wire logic              empty_list,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             action,
  output logic [UP_W-1:0]        min_uplink,
  output logic                   downlink_available
);

  logic      f_valid;
  logic      f_ready;
  vtt_word_t f_word;
  logic      q_valid;
  logic      q_ready;
  vtt_word_t q_word;

  // Front: accept and classify
  vtt_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .current_time        (current_time),
    .pass_start          (pass_start),
    .pass_length         (pass_length),
    .uplink_generation   (uplink_generation),
    .downlink_generation (downlink_generation),
    .last_pass           (last_pass),
    .empty_list          (empty_list),
    .word_valid          (f_valid),
    .word_ready          (f_ready),
    .word                (f_word)
  );

  // Pass queue
  vtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (q_word)
  );

  // Back: list state and action
  vtt_back u_back (
    .clk                (clk),
    .rst                (rst),
    .word_valid         (q_valid),
    .word_ready         (q_ready),
    .word               (q_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .action             (action),
    .min_uplink         (min_uplink),
    .downlink_available (downlink_available)
  );

endmodule

`default_nettype wire

// File: tb/visibility_transceiver_tracker_tb.sv
`timescale 1ns / 1ps

module visibility_transceiver_tracker_tb;
  import vtt_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam int WORD_TARGET  = 1550;

  // One pass word as driven on the input side
  typedef struct {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [UP_W-1:0]   up;
    logic [7:0]        dn;
    logic              last;
    logic              empty;
  } link_pass_t;

  // One transceiver decision as seen on the output side
  typedef struct {
    action_t         act;
    logic [UP_W-1:0] up;
    logic            dn;
  } link_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [TIME_W-1:0] current_time;
  logic [TIME_W-1:0] pass_start;
  logic [LEN_W-1:0]  pass_length;
  logic [UP_W-1:0]   uplink_generation;
  logic [7:0]        downlink_generation;
  logic              last_pass;
  logic              empty_list;
  logic              out_valid;
  logic              out_ready;
  logic [3:0]        action;
  logic [UP_W-1:0]   min_uplink;
  logic              downlink_available;

  // Predictor state: running values of the open list and the values of the last list
  logic [UP_W-1:0] acc_min_up;
  logic            acc_dn;
  logic [UP_W-1:0] kept_up;
  logic            kept_dn;

  link_result_t expected_links[$];
  int           mismatches;
  int           words_sent;
  int           rx_hold_req;
  bit           no_idle;

  visibility_transceiver_tracker i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .current_time       (current_time),
    .pass_start         (pass_start),
    .pass_length        (pass_length),
    .uplink_generation  (uplink_generation),
    .downlink_generation(downlink_generation),
    .last_pass          (last_pass),
    .empty_list         (empty_list),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .action             (action),
    .min_uplink         (min_uplink),
    .downlink_available (downlink_available)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Action from the last list's link state and the new one
  function automatic action_t choose_action(input logic [UP_W-1:0] was_up, input logic was_dn,
                                            input logic [UP_W-1:0] now_up, input logic now_dn);
    logic tx_was;
    logic tx_now;
    tx_was = |was_up;
    tx_now = |now_up;
    if (!tx_now && !now_dn) return (tx_was || was_dn) ? ACT_DISABLE : ACT_KEEP;
    if ((tx_now && !tx_was) || (now_dn && !was_dn)) begin
      if (tx_now && now_dn) return ACT_TX_RX;
      return tx_now ? ACT_TX_ONLY : ACT_RX_ONLY;
    end
    if (tx_was && !tx_now) return ACT_RX_ONLY;
    if (was_dn && !now_dn) return ACT_TX_ONLY;
    case ({now_up != was_up, now_dn != was_dn})
      2'b11: return ACT_BOTH_MOD;
      2'b10: return ACT_TX_MOD;
      2'b01: return ACT_RX_MOD;
      default: return ACT_KEEP;
    endcase
  endfunction

  // Fold one accepted word into the running values; queue a decision if one is due
  function automatic void fold_pass(input link_pass_t p);
    logic [TIME_W-1:0] stop;
    link_result_t      r;
    if (p.empty) begin
      r.act = ACT_UNKNOWN;
      r.up  = '0;
      r.dn  = 1'b0;
      expected_links.push_back(r);
      return;
    end
    stop = p.start + p.len;
    if (p.now >= p.start && p.now < stop) begin
      if (acc_min_up == '0 || p.up < acc_min_up) acc_min_up = p.up;
      if (p.dn != '0) acc_dn = 1'b1;
    end
    if (!p.last) return;
    r.act = choose_action(kept_up, kept_dn, acc_min_up, acc_dn);
    r.up  = acc_min_up;
    r.dn  = acc_dn;
    expected_links.push_back(r);
    kept_up    = acc_min_up;
    kept_dn    = acc_dn;
    acc_min_up = '0;
    acc_dn     = 1'b0;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic link_pass_t pass_of(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] start,
                                         input logic [LEN_W-1:0] len,
                                         input logic [UP_W-1:0] up, input logic [7:0] dn,
                                         input logic last);
    link_pass_t p;
    p.now   = now;
    p.start = start;
    p.len   = len;
    p.up    = up;
    p.dn    = dn;
    p.last  = last;
    p.empty = 1'b0;
    return p;
  endfunction

  // Empty-list word with junk in every other field
  function automatic link_pass_t random_empty();
    link_pass_t p;
    p = pass_of($urandom(), $urandom(), LEN_W'($urandom()), UP_W'($urandom()),
                8'($urandom()), 1'($urandom()));
    p.empty = 1'b1;
    return p;
  endfunction

  // Random pass around a given time, biased toward passes in sight
  function automatic link_pass_t make_pass(input logic [TIME_W-1:0] now, input logic last);
    link_pass_t p;
    p = pass_of(now, '0, '0, '0, '0, last);
    p.len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom()) : LEN_W'($urandom_range(1, 600));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (p.len == '0) p.len = LEN_W'(1);
        p.start = now - $urandom_range(0, p.len - 1);
      end
      6: p.start = now + $urandom_range(1, 5000);
      7: p.start = now - p.len - $urandom_range(0, 5000);
      8: begin
        p.len   = '0;
        p.start = now - $urandom_range(0, 3);
      end
      default: p.start = $urandom();
    endcase
    // small pool of generations so lists often repeat the last one
    case ($urandom_range(0, 5))
      0: p.up = '0;
      1: p.up = 8'd1;
      2: p.up = 8'd2;
      3: p.up = 8'hFF;
      default: p.up = UP_W'($urandom());
    endcase
    p.dn = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
    return p;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_pass(input link_pass_t p);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    current_time        <= p.now;
    pass_start          <= p.start;
    pass_length         <= p.len;
    uplink_generation   <= p.up;
    downlink_generation <= p.dn;
    last_pass           <= p.last;
    empty_list          <= p.empty;
    in_valid            <= 1'b1;
    do @(posedge clk); while (!in_ready);
    fold_pass(p);
    words_sent++;
  endtask

  // Sender pauses until every queued decision has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_links.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_list();
    logic [TIME_W-1:0] now;
    int                n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0: now = $urandom_range(0, 70000);
      1: now = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      default: now = $urandom();
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) send_pass(random_empty());
      send_pass(make_pass(now, i == n - 1));
    end
  endtask

  // Extremes, every reachable action and the special cases
  task automatic test_directed();
    logic [TIME_W-1:0] t0;
    t0 = 32'h6000_0000;
    send_pass(random_empty());
    send_pass(pass_of(t0, t0 + 1, 16'd100, 8'd9, 8'd9, 1'b1));   // starts later: nothing in sight
    send_pass(pass_of(t0, t0, 16'd1, 8'd5, 8'd0, 1'b1));         // first second of a one-second pass
    send_pass(pass_of(t0, t0 - 99, 16'd100, 8'd5, 8'd0, 1'b1));  // last second in sight
    send_pass(pass_of(t0, t0 - 100, 16'd100, 8'd7, 8'd0, 1'b1)); // just ended
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd7, 8'd0, 1'b1));
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd9, 8'd0, 1'b1));
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd9, 8'd3, 1'b1));
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd0, 8'd255, 1'b1));
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd4, 8'd0, 1'b1));
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd4, 8'd1, 1'b1));
    send_pass(pass_of(t0, t0 - 5, 16'd50, 8'd4, 8'd0, 1'b1));
    // uplink zero in sight, then replaced by the next pass in sight
    send_pass(pass_of(t0, t0 - 1, 16'd10, 8'd0, 8'd0, 1'b0));
    send_pass(pass_of(t0, t0 - 1, 16'd10, 8'd200, 8'd0, 1'b0));
    send_pass(pass_of(t0, t0 - 1, 16'd10, 8'd255, 8'd0, 1'b0));
    send_pass(pass_of(t0, t0 + 3, 16'd10, 8'd1, 8'd7, 1'b1));
    // empty list in the middle of a list leaves the running values alone
    send_pass(pass_of(t0, t0 - 1, 16'd10, 8'd3, 8'd0, 1'b0));
    send_pass(random_empty());
    send_pass(pass_of(t0, t0 + 20, 16'd10, 8'd1, 8'd1, 1'b1));
    // pass end wraps past zero
    send_pass(pass_of(32'hFFFF_FF80, 32'hFFFF_FF00, 16'h0200, 8'd2, 8'd2, 1'b1));
    // zero length
    send_pass(pass_of(t0, t0, 16'd0, 8'd2, 8'd2, 1'b1));
    send_pass(pass_of(32'd0, 32'd0, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
    send_pass(pass_of(32'hFFFF_FFFE, 32'hFFFF_0000, 16'hFFFF, 8'd1, 8'd0, 1'b1));
    send_pass(pass_of(32'hFFFF_FFFF, 32'hFFFF_0000, 16'hFFFF, 8'd1, 8'd1, 1'b1));
    wait_for_results();
  endtask

  // Receiver holds off while the sender keeps offering one-pass lists
  task automatic test_receiver_hold();
    rx_hold_req = 300;
    no_idle     = 1'b1;
    repeat (40) send_pass(make_pass($urandom(), 1'b1));
    no_idle = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_lists(input int upto);
    while (words_sent < upto) send_random_list();
  endtask

  // A stretch with no gaps on either side
  task automatic test_no_idle();
    no_idle = 1'b1;
    repeat (30) send_random_list();
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls plus the long hold when one is asked for
  initial begin : rx_side
    int stall_left;
    int hold_left;
    out_ready  = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each result word with the oldest expected decision
  always @(posedge clk) begin
    link_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_links.size() == 0) begin
        report_mismatch($sformatf("unexpected result action %0d min_uplink %0d downlink %0b",
                                  action, min_uplink, downlink_available));
      end else begin
        want = expected_links.pop_front();
        if (action !== want.act)
          report_mismatch($sformatf("action got %0d want %0d", action, want.act));
        if (min_uplink !== want.up)
          report_mismatch($sformatf("min_uplink got %0d want %0d", min_uplink, want.up));
        if (downlink_available !== want.dn)
          report_mismatch($sformatf("downlink_available got %0b want %0b",
                                    downlink_available, want.dn));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("visibility_transceiver_tracker_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    in_valid            = 1'b0;
    current_time        = '0;
    pass_start          = '0;
    pass_length         = '0;
    uplink_generation   = '0;
    downlink_generation = '0;
    last_pass           = 1'b0;
    empty_list          = 1'b0;
    acc_min_up          = '0;
    acc_dn              = 1'b0;
    kept_up             = '0;
    kept_dn             = 1'b0;
    mismatches          = 0;
    words_sent          = 0;
    rx_hold_req         = 0;
    no_idle             = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_receiver_hold();
    test_random_lists(900);
    wait_for_results();
    test_no_idle();
    test_random_lists(WORD_TARGET);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_links.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", expected_links.size()));
    if (mismatches == 0) begin
      $display("visibility_transceiver_tracker_tb OK");
    end else begin
      $display("visibility_transceiver_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
